FILE: rtl/assert_macros.svh
// assertion macros shared by the rtl modules
// no dependencies; assertions drop out when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define TMSM_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("assertion failed");
`define TMSM_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error("assertion failed");
`else
`define TMSM_ASSERT(lbl, clk, rst_n, prop)
`define TMSM_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

FILE: rtl/tmsm_pkg.sv
// types, constants and the operation table of the stretch metric block
// no dependencies
package tmsm_pkg;

	localparam int ACC_W = 208;   // holds every exact intermediate value
	localparam int QUO_W = 68;    // quotient bits kept before the root
	localparam int ROOT_W = 34;   // root bits searched
	localparam int QDEPTH = 2;
	localparam int NUM_OPS = 29;

	typedef logic signed [32:0] dif_t;

	typedef struct packed {
		dif_t [2:0] e1;
		dif_t [2:0] e2;
		dif_t [2:0] f1;
		dif_t [2:0] f2;
	} job_t;

	typedef enum logic [4:0] {
		SRC_E1X, SRC_E1Y, SRC_E1Z,
		SRC_E2X, SRC_E2Y, SRC_E2Z,
		SRC_F1X, SRC_F1Y, SRC_F1Z,
		SRC_F2X, SRC_F2Y, SRC_F2Z,
		SRC_L, SRC_D, SRC_T, SRC_C, SRC_F
	} src_t;

	typedef enum logic [1:0] {INIT_ZERO, INIT_ACC, INIT_C, INIT_N} init_t;

	typedef enum logic [2:0] {
		DST_NONE, DST_L, DST_D, DST_T, DST_C, DST_F, DST_N, DST_DEN
	} dst_t;

	typedef struct packed {
		src_t a;
		src_t b;
		logic neg;
		init_t init;
		dst_t dst;
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_OP, ST_MUL, ST_DCHK, ST_DIV, ST_SQRT, ST_DONE
	} state_t;

	function automatic op_t mk(src_t a, src_t b, logic neg, init_t init, dst_t dst);
		op_t o;
		o.a = a;
		o.b = b;
		o.neg = neg;
		o.init = init;
		o.dst = dst;
		return o;
	endfunction

	// acc = init +/- a*b, b is the narrower factor (bit-serial multiplier)
	function automatic op_t op_rom(logic [4:0] idx);
		op_t o;
		unique case (idx)
			5'd0:  o = mk(SRC_E1X, SRC_E1X, 1'b0, INIT_ZERO, DST_NONE);
			5'd1:  o = mk(SRC_E1Y, SRC_E1Y, 1'b0, INIT_ACC, DST_NONE);
			5'd2:  o = mk(SRC_E1Z, SRC_E1Z, 1'b0, INIT_ACC, DST_L);
			5'd3:  o = mk(SRC_E1X, SRC_E2X, 1'b0, INIT_ZERO, DST_NONE);
			5'd4:  o = mk(SRC_E1Y, SRC_E2Y, 1'b0, INIT_ACC, DST_NONE);
			5'd5:  o = mk(SRC_E1Z, SRC_E2Z, 1'b0, INIT_ACC, DST_D);
			5'd6:  o = mk(SRC_E1Y, SRC_E2Z, 1'b0, INIT_ZERO, DST_NONE);
			5'd7:  o = mk(SRC_E1Z, SRC_E2Y, 1'b1, INIT_ACC, DST_T);
			5'd8:  o = mk(SRC_T, SRC_T, 1'b0, INIT_ZERO, DST_C);
			5'd9:  o = mk(SRC_E1Z, SRC_E2X, 1'b0, INIT_ZERO, DST_NONE);
			5'd10: o = mk(SRC_E1X, SRC_E2Z, 1'b1, INIT_ACC, DST_T);
			5'd11: o = mk(SRC_T, SRC_T, 1'b0, INIT_C, DST_C);
			5'd12: o = mk(SRC_E1X, SRC_E2Y, 1'b0, INIT_ZERO, DST_NONE);
			5'd13: o = mk(SRC_E1Y, SRC_E2X, 1'b1, INIT_ACC, DST_T);
			5'd14: o = mk(SRC_T, SRC_T, 1'b0, INIT_C, DST_C);
			5'd15: o = mk(SRC_F1X, SRC_F1X, 1'b0, INIT_ZERO, DST_NONE);
			5'd16: o = mk(SRC_F1Y, SRC_F1Y, 1'b0, INIT_ACC, DST_NONE);
			5'd17: o = mk(SRC_F1Z, SRC_F1Z, 1'b0, INIT_ACC, DST_F);
			5'd18: o = mk(SRC_C, SRC_F, 1'b0, INIT_ZERO, DST_N);
			5'd19: o = mk(SRC_D, SRC_F1X, 1'b0, INIT_ZERO, DST_NONE);
			5'd20: o = mk(SRC_L, SRC_F2X, 1'b1, INIT_ACC, DST_T);
			5'd21: o = mk(SRC_T, SRC_T, 1'b0, INIT_N, DST_N);
			5'd22: o = mk(SRC_D, SRC_F1Y, 1'b0, INIT_ZERO, DST_NONE);
			5'd23: o = mk(SRC_L, SRC_F2Y, 1'b1, INIT_ACC, DST_T);
			5'd24: o = mk(SRC_T, SRC_T, 1'b0, INIT_N, DST_N);
			5'd25: o = mk(SRC_D, SRC_F1Z, 1'b0, INIT_ZERO, DST_NONE);
			5'd26: o = mk(SRC_L, SRC_F2Z, 1'b1, INIT_ACC, DST_T);
			5'd27: o = mk(SRC_T, SRC_T, 1'b0, INIT_N, DST_N);
			5'd28: o = mk(SRC_C, SRC_L, 1'b0, INIT_ZERO, DST_DEN);
			default: o = mk(SRC_L, SRC_L, 1'b0, INIT_ZERO, DST_NONE);
		endcase
		return o;
	endfunction

endpackage

FILE: rtl/tmsm_front.sv
// front end: takes vertex pairs, keeps the first two, turns a full triangle into edges
// depends on tmsm_pkg
module tmsm_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic signed [31:0]  src_x,
	input  logic signed [31:0]  src_y,
	input  logic signed [31:0]  src_z,
	input  logic signed [31:0]  dst_x,
	input  logic signed [31:0]  dst_y,
	input  logic signed [31:0]  dst_z,
	input  logic                q_full,
	output logic                q_push,
	output tmsm_pkg::job_t      q_job
);

	logic [1:0] count_q;
	logic [31:0] vs_q [2][6];
	logic [31:0] cur [6];
	logic accept;

	assign busy = q_full;
	assign accept = start && !busy;
	assign q_push = accept && count_q[1];

	assign cur[0] = src_x;
	assign cur[1] = src_y;
	assign cur[2] = src_z;
	assign cur[3] = dst_x;
	assign cur[4] = dst_y;
	assign cur[5] = dst_z;

	function automatic tmsm_pkg::dif_t dif(logic [31:0] a, logic [31:0] b);
		return {a[31], a} - {b[31], b};
	endfunction

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			q_job.e1[i] = dif(vs_q[1][i], vs_q[0][i]);
			q_job.e2[i] = dif(cur[i], vs_q[0][i]);
			q_job.f1[i] = dif(vs_q[1][3+i], vs_q[0][3+i]);
			q_job.f2[i] = dif(cur[3+i], vs_q[0][3+i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
		end else if (accept) begin
			count_q <= count_q[1] ? 2'd0 : count_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !count_q[1]) begin
			for (int i = 0; i < 6; i++) begin
				vs_q[count_q[0]][i] <= cur[i];
			end
		end
	end

endmodule

FILE: rtl/tmsm_fifo.sv
// two-entry job queue between the front end and the arithmetic core
// depends on tmsm_pkg and assert_macros.svh
`include "assert_macros.svh"
module tmsm_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  tmsm_pkg::job_t  wdata,
	input  logic            pop,
	output tmsm_pkg::job_t  rdata,
	output logic            full,
	output logic            empty
);

	tmsm_pkg::job_t mem_q [tmsm_pkg::QDEPTH];
	logic wptr_q;
	logic rptr_q;
	logic [1:0] cnt_q;

	assign full = (cnt_q == 2'(tmsm_pkg::QDEPTH));
	assign empty = (cnt_q == 2'd0);
	assign rdata = mem_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wptr_q <= ~wptr_q;
			if (pop) rptr_q <= ~rptr_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wptr_q] <= wdata;
	end

	`TMSM_NEVER(a_push_full, clk, arst_n, push && full && !pop)
	`TMSM_NEVER(a_pop_empty, clk, arst_n, pop && empty)
	`TMSM_ASSERT(a_cnt_range, clk, arst_n, cnt_q <= 2'(tmsm_pkg::QDEPTH))

endmodule

FILE: rtl/tmsm_core.sv
// arithmetic core: bit-serial multiply-accumulate sequence, restoring divide, digit root
// depends on tmsm_pkg and assert_macros.svh
`include "assert_macros.svh"
module tmsm_core #(
	parameter int FRAC_BITS = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            job_valid,
	input  tmsm_pkg::job_t  job,
	output logic            job_pop,
	output logic            done,
	output logic [31:0]     stretch_error,
	output logic            source_degenerate
);

	localparam int W = tmsm_pkg::ACC_W;
	localparam int RW = W + 2;
	localparam int NUMW = W + 2 * FRAC_BITS;
	localparam int QW = tmsm_pkg::QUO_W;
	localparam int RTW = tmsm_pkg::ROOT_W;

	tmsm_pkg::state_t state_q, state_d;
	tmsm_pkg::job_t job_q;
	tmsm_pkg::op_t op;
	logic [4:0] op_idx_q;
	logic last_op;

	logic signed [W-1:0] l_q, d_q, t_q, c_q, f_q, n_q, den_q, acc_q;
	logic [W-1:0] ma_q, mb_q;
	logic msub_q;
	logic signed [W-1:0] opa, opb;

	logic [RW-1:0] rem_q;
	logic [QW-1:0] tail_q, quo_q, x_q, res_q, bitv_q;
	logic [6:0] cnt_q;
	logic sat_q, deg_q;

	logic [NUMW-1:0] num_sh;
	logic [RW-1:0] den2, rem_init, trial, sq_t;
	logic qbit;
	logic [RTW-1:0] rval;
	logic [RTW:0] diff;

	assign op = tmsm_pkg::op_rom(op_idx_q);
	assign last_op = (op_idx_q == 5'(tmsm_pkg::NUM_OPS - 1));

	function automatic logic signed [W-1:0] ext(tmsm_pkg::dif_t v);
		return {{(W-33){v[32]}}, v};
	endfunction

	function automatic logic signed [W-1:0] pick(tmsm_pkg::src_t s, tmsm_pkg::job_t j,
			logic signed [W-1:0] l, logic signed [W-1:0] d, logic signed [W-1:0] t,
			logic signed [W-1:0] c, logic signed [W-1:0] f);
		logic signed [W-1:0] r;
		unique case (s)
			tmsm_pkg::SRC_E1X: r = ext(j.e1[0]);
			tmsm_pkg::SRC_E1Y: r = ext(j.e1[1]);
			tmsm_pkg::SRC_E1Z: r = ext(j.e1[2]);
			tmsm_pkg::SRC_E2X: r = ext(j.e2[0]);
			tmsm_pkg::SRC_E2Y: r = ext(j.e2[1]);
			tmsm_pkg::SRC_E2Z: r = ext(j.e2[2]);
			tmsm_pkg::SRC_F1X: r = ext(j.f1[0]);
			tmsm_pkg::SRC_F1Y: r = ext(j.f1[1]);
			tmsm_pkg::SRC_F1Z: r = ext(j.f1[2]);
			tmsm_pkg::SRC_F2X: r = ext(j.f2[0]);
			tmsm_pkg::SRC_F2Y: r = ext(j.f2[1]);
			tmsm_pkg::SRC_F2Z: r = ext(j.f2[2]);
			tmsm_pkg::SRC_L: r = l;
			tmsm_pkg::SRC_D: r = d;
			tmsm_pkg::SRC_T: r = t;
			tmsm_pkg::SRC_C: r = c;
			tmsm_pkg::SRC_F: r = f;
			default: r = '0;
		endcase
		return r;
	endfunction

	assign opa = pick(op.a, job_q, l_q, d_q, t_q, c_q, f_q);
	assign opb = pick(op.b, job_q, l_q, d_q, t_q, c_q, f_q);

	// dividend is N scaled by 2^(2*frac), divisor is 2*L*C
	assign num_sh = {n_q, {(2*FRAC_BITS){1'b0}}};
	assign den2 = {1'b0, den_q, 1'b0};
	assign rem_init = {{(RW-(NUMW-QW)){1'b0}}, num_sh[NUMW-1:QW]};
	assign trial = {rem_q[RW-2:0], tail_q[QW-1]};
	assign qbit = (trial >= den2);
	assign sq_t = RW'(res_q) + RW'(bitv_q);

	assign rval = sat_q ? {RTW{1'b1}} : res_q[RTW-1:0];
	assign diff = ({1'b0, rval} >= (RTW+1)'(1) << FRAC_BITS)
		? {1'b0, rval} - ((RTW+1)'(1) << FRAC_BITS)
		: ((RTW+1)'(1) << FRAC_BITS) - {1'b0, rval};

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tmsm_pkg::ST_IDLE: if (job_valid) state_d = tmsm_pkg::ST_OP;
			tmsm_pkg::ST_OP: state_d = tmsm_pkg::ST_MUL;
			tmsm_pkg::ST_MUL: begin
				if (mb_q == '0) state_d = last_op ? tmsm_pkg::ST_DCHK : tmsm_pkg::ST_OP;
			end
			tmsm_pkg::ST_DCHK: begin
				if (c_q == '0 || rem_init >= den2) state_d = tmsm_pkg::ST_DONE;
				else state_d = tmsm_pkg::ST_DIV;
			end
			tmsm_pkg::ST_DIV: if (cnt_q == 7'd0) state_d = tmsm_pkg::ST_SQRT;
			tmsm_pkg::ST_SQRT: if (cnt_q == 7'd0) state_d = tmsm_pkg::ST_DONE;
			tmsm_pkg::ST_DONE: state_d = tmsm_pkg::ST_IDLE;
			default: state_d = tmsm_pkg::ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		job_pop = (state_q == tmsm_pkg::ST_IDLE) && job_valid;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tmsm_pkg::ST_IDLE;
			done <= 1'b0;
		end else begin
			state_q <= state_d;
			done <= (state_q == tmsm_pkg::ST_DONE);
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			tmsm_pkg::ST_IDLE: begin
				job_q <= job;
				op_idx_q <= 5'd0;
			end
			tmsm_pkg::ST_OP: begin
				ma_q <= opa[W-1] ? -opa : opa;
				mb_q <= opb[W-1] ? -opb : opb;
				msub_q <= opa[W-1] ^ opb[W-1] ^ op.neg;
				unique case (op.init)
					tmsm_pkg::INIT_ZERO: acc_q <= '0;
					tmsm_pkg::INIT_ACC: acc_q <= acc_q;
					tmsm_pkg::INIT_C: acc_q <= c_q;
					tmsm_pkg::INIT_N: acc_q <= n_q;
					default: acc_q <= '0;
				endcase
			end
			tmsm_pkg::ST_MUL: begin
				if (mb_q == '0) begin
					unique case (op.dst)
						tmsm_pkg::DST_NONE: ;
						tmsm_pkg::DST_L: l_q <= acc_q;
						tmsm_pkg::DST_D: d_q <= acc_q;
						tmsm_pkg::DST_T: t_q <= acc_q;
						tmsm_pkg::DST_C: c_q <= acc_q;
						tmsm_pkg::DST_F: f_q <= acc_q;
						tmsm_pkg::DST_N: n_q <= acc_q;
						tmsm_pkg::DST_DEN: den_q <= acc_q;
						default: ;
					endcase
					op_idx_q <= op_idx_q + 5'd1;
				end else begin
					if (mb_q[0]) acc_q <= msub_q ? acc_q - ma_q : acc_q + ma_q;
					ma_q <= ma_q << 1;
					mb_q <= mb_q >> 1;
				end
			end
			tmsm_pkg::ST_DCHK: begin
				deg_q <= (c_q == '0);
				sat_q <= (rem_init >= den2);
				rem_q <= rem_init;
				tail_q <= num_sh[QW-1:0];
				quo_q <= '0;
				cnt_q <= 7'(QW - 1);
			end
			tmsm_pkg::ST_DIV: begin
				rem_q <= qbit ? trial - den2 : trial;
				tail_q <= tail_q << 1;
				quo_q <= {quo_q[QW-2:0], qbit};
				if (cnt_q == 7'd0) begin
					x_q <= {quo_q[QW-2:0], qbit};
					res_q <= '0;
					bitv_q <= QW'(1) << (QW - 2);
					cnt_q <= 7'(RTW - 1);
				end else begin
					cnt_q <= cnt_q - 7'd1;
				end
			end
			tmsm_pkg::ST_SQRT: begin
				// digit-by-digit root, one result bit per cycle
				if (RW'(x_q) >= sq_t) begin
					x_q <= x_q - QW'(sq_t);
					res_q <= (res_q >> 1) + bitv_q;
				end else begin
					res_q <= res_q >> 1;
				end
				bitv_q <= bitv_q >> 2;
				cnt_q <= cnt_q - 7'd1;
			end
			tmsm_pkg::ST_DONE: begin
				source_degenerate <= deg_q;
				stretch_error <= (deg_q || diff[RTW:32] != '0) ? 32'hFFFF_FFFF : diff[31:0];
			end
			default: ;
		endcase
	end

	`TMSM_ASSERT(a_done_pulse, clk, arst_n, done |=> !done)
	`TMSM_ASSERT(a_deg_sat, clk, arst_n, (done && source_degenerate) |-> (stretch_error == 32'hFFFF_FFFF))
	`TMSM_ASSERT(a_seq_end, clk, arst_n, (state_q == tmsm_pkg::ST_MUL && mb_q == '0 && last_op) |=> (state_q == tmsm_pkg::ST_DCHK))

endmodule

FILE: rtl/triangle_map_stretch_metric_top.sv
// L2 stretch metric of a source/target triangle pair, top level
// depends on tmsm_pkg, tmsm_front, tmsm_fifo, tmsm_core
//
// usage: each transaction carries one vertex pair (src_x/y/z, dst_x/y/z, signed
// fixed point with FRAC_BITS fraction bits). A transaction is taken at a rising
// edge with start high and busy low. Every third transaction closes a triangle
// and later yields one result: done is high for one cycle with stretch_error
// (unsigned, saturating) and source_degenerate (zero source area, error all ones).
// The first two vertices only fill a store; the third turns the triangle into
// edges and queues it (two triangles deep), so busy rises only while the queue
// is full.
// each triangle runs through the bit-serial multiply-accumulate unit: 29
// products, each stepping through the magnitude bits of its multiplier (up to
// 99 bits), then a 68-bit restoring divide and a 34-bit digit root (both
// skipped for a degenerate source or a saturated result), so the time to done
// depends on operand magnitudes.
// results cannot be held off; the receiver must take done when it appears.
// reset clears the vertex count, the queue and the sequencer.
module triangle_map_stretch_metric_top #(
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [31:0] src_x,
	input  logic signed [31:0] src_y,
	input  logic signed [31:0] src_z,
	input  logic signed [31:0] dst_x,
	input  logic signed [31:0] dst_y,
	input  logic signed [31:0] dst_z,
	output logic               done,
	output logic [31:0]        stretch_error,
	output logic               source_degenerate
);

	tmsm_pkg::job_t push_job, pop_job;
	logic q_push, q_pop, q_full, q_empty;

	tmsm_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.src_x  (src_x),
		.src_y  (src_y),
		.src_z  (src_z),
		.dst_x  (dst_x),
		.dst_y  (dst_y),
		.dst_z  (dst_z),
		.q_full (q_full),
		.q_push (q_push),
		.q_job  (push_job)
	);

	tmsm_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (push_job),
		.pop    (q_pop),
		.rdata  (pop_job),
		.full   (q_full),
		.empty  (q_empty)
	);

	tmsm_core #(.FRAC_BITS(FRAC_BITS)) u_core (
		.clk               (clk),
		.arst_n            (arst_n),
		.job_valid         (!q_empty),
		.job               (pop_job),
		.job_pop           (q_pop),
		.done              (done),
		.stretch_error     (stretch_error),
		.source_degenerate (source_degenerate)
	);

endmodule
